FILE: hw/rtl/cascaded_delta_codec_core_assert.svh
// Assertion macros for the cascaded delta codec RTL.
`ifndef CASCADED_DELTA_CODEC_CORE_ASSERT_SVH
`define CASCADED_DELTA_CODEC_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdc assertion failed");
`define CDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdc assertion failed");
`else
`define CDC_ASSERT_NOW(lbl, ante, cons)
`define CDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/cdc_pkg.sv
// Types and constants of the cascaded delta codec.
package cdc_pkg;

  localparam int MAX_ORDER  = 8;
  localparam int SMP_W      = 16;
  localparam int FAIL_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [FAIL_W-1:0] FAIL_NONE = '0;
  localparam logic [FAIL_W-1:0] FAIL_SAT  = 4'd15;

  localparam logic signed [SMP_W:0] DIFF_POS_LIM = 17'sd32767;
  localparam logic signed [SMP_W:0] DIFF_NEG_LIM = -17'sd32767;

  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER       = 2'd1;

  // One sample request moving down the chain.
  typedef struct packed {
    logic                    vld;
    logic signed [SMP_W-1:0] smp;
    logic                    start;
    logic [FAIL_W-1:0]       fail;
  } cdc_flow_t;

endpackage

FILE: hw/rtl/cdc_cell.sv
// One delta stage: holds its previous value and hands the sample on.
module cdc_cell
  import cdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                en,
  input  logic                decode_mode,
  input  logic [FAIL_W-1:0]   stage_num,
  input  cdc_flow_t           flow_i,
  output cdc_flow_t           flow_o
);

  logic signed [SMP_W-1:0] prev_r;
  logic signed [SMP_W-1:0] prev_nxt;
  logic signed [SMP_W:0]   diff;
  logic                    ovf;
  logic                    active;
  cdc_flow_t               flow_r;
  cdc_flow_t               flow_nxt;

  assign active = flow_i.vld && en;
  assign diff   = {flow_i.smp[SMP_W-1], flow_i.smp} - {prev_r[SMP_W-1], prev_r};
  assign ovf    = (diff > DIFF_POS_LIM) || (diff < DIFF_NEG_LIM);

  always_comb begin
    flow_nxt = flow_i;
    prev_nxt = prev_r;
    if (active) begin
      if (flow_i.start) begin
        prev_nxt = flow_i.smp;
      end else if (decode_mode) begin
        flow_nxt.smp = flow_i.smp + prev_r;
        prev_nxt     = flow_nxt.smp;
      end else begin
        flow_nxt.smp = diff[SMP_W-1:0];
        prev_nxt     = flow_i.smp;
        // keep the first stage that overflowed for this request
        if (ovf && (flow_i.fail == FAIL_NONE)) begin
          flow_nxt.fail = stage_num;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      flow_r <= '0;
    end else if (adv) begin
      prev_r <= prev_nxt;
      flow_r <= flow_nxt;
    end
  end

  assign flow_o = flow_r;

endmodule

FILE: hw/rtl/cdc_out.sv
// Output register with per-block failure tracking.
`include "cascaded_delta_codec_core_assert.svh"
module cdc_out
  import cdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  cdc_flow_t         flow_i,
  output logic              out_vld,
  output logic [SMP_W-1:0]  out_smp,
  output logic [FAIL_W-1:0] out_fail
);

  logic [FAIL_W-1:0] blk_r;
  logic [FAIL_W-1:0] blk_nxt;
  logic              out_vld_r;
  logic [SMP_W-1:0]  out_smp_r;
  logic [FAIL_W-1:0] out_fail_r;

  // lowest nonzero stage number wins within a block
  always_comb begin
    if (flow_i.start || (blk_r == FAIL_NONE)) begin
      blk_nxt = flow_i.fail;
    end else if ((flow_i.fail != FAIL_NONE) && (flow_i.fail < blk_r)) begin
      blk_nxt = flow_i.fail;
    end else begin
      blk_nxt = blk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r     <= FAIL_NONE;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= flow_i.vld;
      if (flow_i.vld) begin
        blk_r <= blk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && flow_i.vld) begin
      out_smp_r  <= flow_i.smp;
      out_fail_r <= blk_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_smp  = out_smp_r;
  assign out_fail = out_fail_r;

  `CDC_ASSERT_NOW(a_fail_tracks_block, out_vld_r, out_fail_r == blk_r)
  `CDC_ASSERT_NEXT(a_start_resets_fail, adv && flow_i.vld && flow_i.start,
                   out_fail_r == $past(flow_i.fail))
  `CDC_ASSERT_NEXT(a_fail_never_rises,
                   adv && flow_i.vld && !flow_i.start && (blk_r != FAIL_NONE),
                   (blk_r != FAIL_NONE) && (blk_r <= $past(blk_r)))

endmodule

FILE: hw/rtl/cascaded_delta_codec_core.sv
// Top level of the cascaded delta codec: config registers, cell chain, output.
//
//  port group | dir | payload
//  -----------+-----+-----------------------------------------------
//  in_        | in  | tdata: sample_in[15:0]; tuser: block_start
//  out_       | out | tdata: sample_out[15:0]; tuser: failed_stage
//  cfg_       | in  | index 0 decode_mode, index 1 order
//
// One sample per cycle sustained while the output is not stalled; the path holds
// MAX_ORDER + 1 registers, one per cell of the chain plus the output register.
// Every request walks all cells; cells past order pass it unchanged. The whole
// chain advances when the output register is empty or being taken. Reset
// clears all stage state and failure tracking; config is always ready.
module cascaded_delta_codec_core
  import cdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] sample_in
  input  logic [0:0]            in_tuser,   // [0] block_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] sample_out
  output logic [3:0]            out_tuser,  // [3:0] failed_stage
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic             decode_mode_r;
  logic [3:0]       order_r;
  logic             adv;
  logic             out_vld;
  cdc_flow_t        flow [0:MAX_ORDER];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      order_r       <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DECODE_MODE: decode_mode_r <= cfg_data[0];
        REG_ORDER:       order_r       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_vld || out_tready;
  assign in_tready = adv;

  assign flow[0].vld   = in_tvalid;
  assign flow[0].smp   = in_tdata[SMP_W-1:0];
  assign flow[0].start = in_tuser[0];
  assign flow[0].fail  = FAIL_NONE;

  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
    localparam logic [FAIL_W-1:0] NUM = (k + 1 > 15) ? FAIL_SAT : FAIL_W'(k + 1);
    logic en;
    assign en = order_r > 4'(k);

    cdc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .en          (en),
      .decode_mode (decode_mode_r),
      .stage_num   (NUM),
      .flow_i      (flow[k]),
      .flow_o      (flow[k+1])
    );
  end

  cdc_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .flow_i   (flow[MAX_ORDER]),
    .out_vld  (out_vld),
    .out_smp  (out_tdata),
    .out_fail (out_tuser)
  );

  assign out_tvalid = out_vld;

endmodule

FILE: test/tb_top.sv
// Testbench for the cascaded delta codec core: directed and random streams vs. a predictor.
`timescale 1ns / 1ps

module tb_top
  import cdc_pkg::*;
;

  localparam int LATENCY     = MAX_ORDER + 1;
  localparam int HOLD_CYCLES = 80;

  // Indexes past the two real registers; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [SMP_W-1:0]  smp;
    logic [FAIL_W-1:0] fail;
  } codec_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;  // [15:0] sample_in
  logic [0:0]            in_tuser   = '0;  // [0] block_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;        // [15:0] sample_out
  logic [3:0]            out_tuser;        // [3:0] failed_stage
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Predictor copy of the chain state and the registers.
  logic [SMP_W-1:0]  stage_hist [MAX_ORDER];
  logic [FAIL_W-1:0] worst_stage;
  logic              decode_en;
  logic [3:0]        stage_count;

  codec_result_t expected_samples[$];
  int            errors         = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  logic          hold_on        = 1'b0;
  event          hold_go;

  cascaded_delta_codec_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Run one sample through the active stages and update the shadow state.
  function automatic codec_result_t codec_step(logic [SMP_W-1:0] x, logic first);
    int               active;
    int               diff;
    logic [SMP_W-1:0] y;
    logic [FAIL_W-1:0] num;
    codec_result_t    r;
    active = (stage_count > MAX_ORDER) ? MAX_ORDER : int'(stage_count);
    if (first) worst_stage = FAIL_NONE;
    for (int k = 0; k < active; k++) begin
      if (first) begin
        y = x;
        stage_hist[k] = x;
      end else if (decode_en) begin
        y = x + stage_hist[k];
        stage_hist[k] = y;
      end else begin
        diff = int'($signed(x)) - int'($signed(stage_hist[k]));
        if (diff > DIFF_POS_LIM || diff < DIFF_NEG_LIM) begin
          num = (k + 1 > int'(FAIL_SAT)) ? FAIL_SAT : FAIL_W'(k + 1);
          if (worst_stage == FAIL_NONE || num < worst_stage) worst_stage = num;
        end
        y = x - stage_hist[k];
        stage_hist[k] = x;
      end
      x = y;
    end
    r.smp  = x;
    r.fail = worst_stage;
    return r;
  endfunction

  task automatic send_sample(logic [15:0] smp, logic first);
    cfg_valid <= 1'b0;
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    expected_samples.push_back(codec_step(smp, first));
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DECODE_MODE) decode_en = val[0];
    else if (idx == REG_ORDER) stage_count = val;
  endtask

  // Stop offering requests until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  task automatic test_power_up_state();
    // No block start yet: stage 1 differences against zero.
    send_sample(16'h1234, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
  endtask

  task automatic test_encode_limits();
    wait_drained();
    set_reg(REG_ORDER, CFG_DATA_W'(1));
    send_sample(16'h8000, 1'b1);
    send_sample(16'h8001, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h8001, 1'b0);  // difference right at the negative limit
    send_sample(16'h7FFF, 1'b0);
    wait_drained();
    set_reg(REG_ORDER, CFG_DATA_W'(MAX_ORDER));
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
  endtask

  task automatic test_decode_wrap();
    wait_drained();
    set_reg(REG_DECODE_MODE, CFG_DATA_W'(1));
    set_reg(REG_ORDER, CFG_DATA_W'(2));
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
  endtask

  task automatic test_order_limits();
    wait_drained();
    set_reg(REG_DECODE_MODE, CFG_DATA_W'(0));
    set_reg(REG_ORDER, CFG_DATA_W'(15));
    send_sample(16'h0100, 1'b1);
    send_sample(16'hFF00, 1'b0);
    wait_drained();
    set_reg(REG_ORDER, CFG_DATA_W'(0));
    send_sample(16'h1234, 1'b0);
    send_sample(16'h8000, 1'b1);
    wait_drained();
    set_reg(REG_ORDER, CFG_DATA_W'(MAX_ORDER + 1));
    send_sample(16'h0001, 1'b0);
  endtask

  task automatic test_mid_block_switch();
    wait_drained();
    set_reg(REG_DECODE_MODE, 4'b1110);
    set_reg(REG_ORDER, CFG_DATA_W'(3));
    send_sample(16'h0010, 1'b1);
    send_sample(16'h0020, 1'b0);
    wait_drained();
    set_reg(REG_DECODE_MODE, 4'b1111);
    send_sample(16'h0005, 1'b0);
    wait_drained();
    // Fewer stages: the upper ones keep their history.
    set_reg(REG_ORDER, CFG_DATA_W'(1));
    send_sample(16'h0007, 1'b0);
    wait_drained();
    set_reg(REG_DECODE_MODE, CFG_DATA_W'(0));
    set_reg(REG_ORDER, CFG_DATA_W'(3));
    set_reg(REG_SPARE_2, 4'hF);
    set_reg(REG_SPARE_3, 4'hA);
    send_sample(16'h0009, 1'b0);
  endtask

  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    -> hold_go;
    repeat (4 * MAX_ORDER) send_sample(16'($urandom), 1'($urandom_range(1)));
    wait_drained();
  endtask

  task automatic test_random_stream(int n_items, int idle_pct, int stall_pct);
    int          sent;
    int          blk_len;
    int          amp;
    int          lvl;
    logic        first;
    logic [15:0] smp;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_drained();
      set_reg(REG_DECODE_MODE, CFG_DATA_W'($urandom_range(15)));
      if ($urandom_range(4) == 0) set_reg(REG_ORDER, CFG_DATA_W'($urandom_range(15)));
      else set_reg(REG_ORDER, CFG_DATA_W'($urandom_range(1, MAX_ORDER)));
      if ($urandom_range(5) == 0)
        set_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
      repeat ($urandom_range(1, 4)) begin
        blk_len = $urandom_range(1, 40);
        amp     = 1 << $urandom_range(14);
        lvl     = int'($urandom_range(65535)) - 32768;
        for (int j = 0; j < blk_len; j++) begin
          if (decode_en) begin
            smp = 16'(int'($urandom_range(2 * amp)) - amp);
          end else begin
            // Smooth walk so that high orders do not overflow on every sample.
            lvl = lvl + int'($urandom_range(2 * amp)) - amp;
            if (lvl > 32767) lvl = 32767;
            if (lvl < -32768) lvl = -32768;
            smp = 16'(lvl);
          end
          first = (j == 0) && ($urandom_range(9) != 0);
          if ($urandom_range(11) == 0) begin
            smp   = 16'($urandom);
            first = 1'($urandom_range(1));
          end
          send_sample(smp, first);
          sent++;
        end
      end
    end
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin : result_check
    codec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: sample %h stage %0d", $time, out_tdata, out_tuser);
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want.smp) begin
          errors++;
          $display("%0t: sample_out expected %h actual %h", $time, want.smp, out_tdata);
        end
        if (out_tuser !== want.fail) begin
          errors++;
          $display("%0t: failed_stage expected %0d actual %0d", $time, want.fail, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_on) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold the receiver off for a fixed stretch when asked.
  initial forever begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    for (int k = 0; k < MAX_ORDER; k++) stage_hist[k] = '0;
    worst_stage = FAIL_NONE;
    decode_en   = 1'b0;
    stage_count = 4'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_power_up_state();
    test_encode_limits();
    test_decode_wrap();
    test_order_limits();
    test_mid_block_switch();
    test_output_hold();
    test_random_stream(250, 0, 0);
    test_random_stream(250, 76, 0);
    test_random_stream(250, 0, 76);
    test_random_stream(250, 34, 34);
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
